// ===== hdl/input_restricted_deque_top_macros.svh =====
// Assertion helpers for the deque block
`ifndef INPUT_RESTRICTED_DEQUE_TOP_MACROS_SVH
`define INPUT_RESTRICTED_DEQUE_TOP_MACROS_SVH

// checked while out of reset
`define IRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define IRD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/ird_pkg.sv =====
`default_nettype none

package ird_pkg;

  localparam logic [1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [1:0] KIND_POP_FRONT  = 2'd1;
  localparam logic [1:0] KIND_POP_BACK   = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] pop_value;
    logic [3:0]         occupancy;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/ird_ctrl.sv =====
`default_nettype none

module ird_ctrl
  import ird_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req_valid) state_next = S_EXEC;
      S_EXEC: if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign req_ready   = (state == S_IDLE);
  assign cmd.capture = req_valid && (state == S_IDLE);
  assign cmd.commit  = (state == S_EXEC) && stat.out_free;

endmodule

`default_nettype wire

// ===== hdl/ird_dp.sv =====
`default_nettype none

module ird_dp
  import ird_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire ctl_cmd_t cmd,
  output dp_stat_t      stat,
  input  wire req_t     req,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output rsp_t          rsp
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

  logic [31:0]      mem [DEPTH];
  logic [31:0]      rd_data;
  req_t             rq;
  logic [IDX_W-1:0] front, front_next;
  logic [IDX_W-1:0] back, back_next;
  logic [CNT_W-1:0] count, count_next;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  logic             wr_en;
  logic [1:0]       st;
  logic [31:0]      popv;

  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i);
    return (i == '0) ? LAST_IDX : i - 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + 1'b1;
  endfunction

  assign rd_addr = (req.kind == KIND_POP_BACK) ? back : front;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rq      <= req;
      rd_data <= mem[rd_addr];
    end
    if (wr_en) mem[wr_addr] <= rq.push_value;
  end

  always_comb begin
    front_next = front;
    back_next  = back;
    count_next = count;
    st         = ST_DONE;
    popv       = '0;
    wr_en      = 1'b0;
    wr_addr    = front;
    unique case (rq.kind)
      KIND_PUSH_FRONT: begin
        if (count == FULL_CNT) begin
          st = ST_FULL;
        end else begin
          wr_en      = cmd.commit;
          wr_addr    = (count == '0) ? '0 : step_down(front);
          front_next = wr_addr;
          if (count == '0) back_next = '0;
          count_next = count + 1'b1;
        end
      end
      KIND_POP_FRONT: begin
        if (count == '0) begin
          st = ST_EMPTY;
        end else begin
          popv       = rd_data;
          count_next = count - 1'b1;
          front_next = (count == ONE_CNT) ? '0 : step_up(front);
          if (count == ONE_CNT) back_next = '0;
        end
      end
      KIND_POP_BACK: begin
        if (count == '0) begin
          st = ST_EMPTY;
        end else begin
          popv       = rd_data;
          count_next = count - 1'b1;
          back_next  = (count == ONE_CNT) ? '0 : step_down(back);
          if (count == ONE_CNT) front_next = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      back  <= '0;
      count <= '0;
    end else if (cmd.commit) begin
      front <= front_next;
      back  <= back_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)             rsp_valid <= 1'b0;
    else if (cmd.commit) rsp_valid <= 1'b1;
    else if (rsp_ready)  rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.status    <= st;
      rsp.pop_value <= popv;
      rsp.occupancy <= 4'(count_next);
    end
  end

  assign stat.out_free = !rsp_valid || rsp_ready;

`include "input_restricted_deque_top_macros.svh"

  `IRD_ASSERT(a_count_bound, count <= FULL_CNT, "entry count above depth")
  `IRD_ASSERT(a_empty_idx, (count == '0) |-> (front == '0 && back == '0), "empty with moved index")
  `IRD_ASSERT(a_push_grow, (cmd.commit && rq.kind == KIND_PUSH_FRONT && count != FULL_CNT) |=> (count == CNT_W'($past(count) + 1'b1)), "push did not grow count")
  `IRD_ASSERT_ALWAYS(a_one_write, wr_en |-> cmd.commit, "memory write outside commit")

endmodule

`default_nettype wire

// ===== hdl/input_restricted_deque_top.sv =====
// The request word and its slot read are registered on accept; the commit follows,
// held while a stalled result is not taken, and sets the result valid flag.
// No new request is accepted until the previous one commits.
// Reset (rst, synchronous): clears indices, count and the result valid flag;
// slot memory contents are left as they are.
`default_nettype none

module input_restricted_deque_top
  import ird_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  ird_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ird_dp #(.DEPTH(DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
